// ===== design/tcee_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console escape engine package
// Geometry, character codes, request codes and sequencer states.
// ----------------------------------------------------------------------------
package tcee_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int BUF_LINES  = 64;
  localparam int TAB_WIDTH  = 8;
  localparam int ESC_PARAMS = 2;

  localparam int BUF_CELLS = COLS * BUF_LINES;
  localparam int SCR_CELLS = COLS * ROWS;

  // Fixed field widths.
  localparam int ADDR_W  = 13;
  localparam int DATA_W  = 16;
  localparam int PARAM_W = 16;
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;

  // Widths that follow from the geometry.
  localparam int ROW_W   = $clog2(BUF_LINES + 1);
  localparam int COL_W   = $clog2(COLS + 1);
  localparam int VL_W    = $clog2(BUF_LINES);
  localparam int PIDX_W  = $clog2(ESC_PARAMS + 1);
  localparam int GUARD_W = $clog2(BUF_LINES + 2);
  localparam int GUARD_MAX = BUF_LINES + 1;

  localparam logic [PARAM_W-1:0] PMAX = 16'hFFFF;
  localparam logic [CHAR_W-1:0] COLOR_RST = 8'h07;

  localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
  localparam logic [CHAR_W-1:0] CH_J     = 8'h4A;
  localparam logic [CHAR_W-1:0] CH_K     = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_LBR   = 8'h5B;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE = 2'd0,
    FN_UP    = 2'd1,
    FN_DOWN  = 2'd2,
    FN_READ  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_START = 2'd1,
    ESC_CSI   = 2'd2
  } esc_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MV_RD,
    ST_MV_WR,
    ST_FILL,
    ST_VIEW,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== design/tcee_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module tcee_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5120
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/text_console_escape_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console escape engine
// Character-cell terminal with a subset of the ANSI escape codes.
// ----------------------------------------------------------------------------
// One request is handled at a time. A character outside an escape sequence
// may also scroll the view line by line to follow the cursor, blanking a
// line's worth of cells from the cursor at each step. Every cell that a
// request clears takes one write and every cell that it moves a read and a
// write, through the single port of the cell memory; a line wrap moves 1920
// cells and clears 80. After reset the block blanks all 5120 cells of the
// cell memory before it takes the first request.
module text_console_escape_engine_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcee_pkg::CHAR_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tcee_pkg::FUNC_W-1:0]    func_i,
  input  logic [tcee_pkg::CHAR_W-1:0]    ch_i,
  input  logic [tcee_pkg::ADDR_W-1:0]    cell_addr_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tcee_pkg::ADDR_W-1:0]    cursor_pos_o,
  output logic [tcee_pkg::ADDR_W-1:0]    display_start_o,
  output logic [tcee_pkg::DATA_W-1:0]    cell_data_o,
  output logic                           buffer_wrapped_o
);

  localparam int AW = tcee_pkg::ADDR_W;

  tcee_pkg::state_e state_q, state_d;
  tcee_pkg::esc_e   esc_q, esc_d;

  logic [AW-1:0]                  clr_q, clr_d;
  logic [tcee_pkg::CHAR_W-1:0]    color_q;
  logic [tcee_pkg::FUNC_W-1:0]    func_q, func_d;
  logic [tcee_pkg::CHAR_W-1:0]    ch_q, ch_d;
  logic [AW-1:0]                  addr_q, addr_d;
  logic [tcee_pkg::ROW_W-1:0]     row_q, row_d;
  logic [tcee_pkg::COL_W-1:0]     col_q, col_d;
  logic [tcee_pkg::VL_W-1:0]      vline_q, vline_d;
  logic                           full_q, full_d;
  logic                           intro_q, intro_d;
  logic [tcee_pkg::PARAM_W-1:0]   par_q [tcee_pkg::ESC_PARAMS];
  logic [tcee_pkg::PARAM_W-1:0]   par_d [tcee_pkg::ESC_PARAMS];
  logic [tcee_pkg::PIDX_W-1:0]    pidx_q, pidx_d;
  logic [AW-1:0]                  mv_src_q, mv_src_d, mv_dst_q, mv_dst_d;
  logic [AW-1:0]                  mv_len_q, mv_len_d;
  logic                           mv_bwd_q, mv_bwd_d;
  logic [AW-1:0]                  fill_pos_q, fill_pos_d, fill_len_q, fill_len_d;
  logic                           view_q, view_d;
  logic [tcee_pkg::GUARD_W-1:0]   guard_q, guard_d;
  logic [tcee_pkg::DATA_W-1:0]    data_q, data_d;
  logic                           out_valid_q, out_valid_d;
  logic [AW-1:0]                  out_cur_q, out_cur_d, out_vs_q, out_vs_d;
  logic [tcee_pkg::DATA_W-1:0]    out_data_q, out_data_d;
  logic                           out_wrap_q, out_wrap_d;

  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [tcee_pkg::DATA_W-1:0]    ram_wdata, ram_rdata;

  logic [AW-1:0]                  cur_pos;
  logic [tcee_pkg::DATA_W-1:0]    blank;
  logic                           in_view;
  logic [tcee_pkg::VL_W-1:0]      vup;

  function automatic logic [tcee_pkg::VL_W-1:0] f_view_up(
    input logic [tcee_pkg::VL_W-1:0]  vl,
    input logic [tcee_pkg::ROW_W-1:0] y,
    input logic                       full
  );
    int v;
    int r;
    logic [tcee_pkg::VL_W-1:0] res;
    v   = int'(vl);
    r   = int'(y);
    res = vl;
    if (!full) begin
      if (r >= v + tcee_pkg::ROWS) res = tcee_pkg::VL_W'(v + 1);
    end else if (v + tcee_pkg::ROWS - 1 != r) begin
      if (v + tcee_pkg::ROWS >= tcee_pkg::BUF_LINES) res = '0;
      else res = tcee_pkg::VL_W'(v + 1);
    end
    return res;
  endfunction

  function automatic logic [tcee_pkg::VL_W-1:0] f_view_down(
    input logic [tcee_pkg::VL_W-1:0]  vl,
    input logic [tcee_pkg::ROW_W-1:0] y,
    input logic                       full
  );
    int v;
    int r;
    int nxt;
    logic [tcee_pkg::VL_W-1:0] res;
    v   = int'(vl);
    r   = int'(y);
    res = vl;
    nxt = (r + 1 == tcee_pkg::BUF_LINES) ? 0 : r + 1;
    if (!full) begin
      if (v > 0) res = tcee_pkg::VL_W'(v - 1);
    end else if (v != nxt) begin
      if (r >= tcee_pkg::BUF_LINES - tcee_pkg::ROWS) begin
        if (v != 0) res = tcee_pkg::VL_W'(v - 1);
      end else if (v == 0) begin
        res = tcee_pkg::VL_W'(tcee_pkg::BUF_LINES - tcee_pkg::ROWS);
      end else begin
        res = tcee_pkg::VL_W'(v - 1);
      end
    end
    return res;
  endfunction

  assign cur_pos = AW'(int'(row_q) * tcee_pkg::COLS + int'(col_q));
  assign blank   = {color_q, tcee_pkg::CH_SPACE};
  assign in_view = (int'(vline_q) <= int'(row_q)) &&
                   (int'(row_q) < int'(vline_q) + tcee_pkg::ROWS);
  assign vup     = f_view_up(vline_q, row_q, full_q);

  tcee_ram #(
    .WIDTH (tcee_pkg::DATA_W),
    .DEPTH (tcee_pkg::BUF_CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcee_pkg::ST_CLEAR: begin
        if (clr_q == AW'(tcee_pkg::BUF_CELLS - 1)) state_d = tcee_pkg::ST_IDLE;
      end
      tcee_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tcee_pkg::ST_EXEC;
      end
      tcee_pkg::ST_EXEC: begin
        if (func_q == tcee_pkg::FN_READ && addr_q < AW'(tcee_pkg::BUF_CELLS)) begin
          state_d = tcee_pkg::ST_RD_WAIT;
        end else if (mv_len_d != '0) begin
          state_d = tcee_pkg::ST_MV_RD;
        end else begin
          state_d = tcee_pkg::ST_FILL;
        end
      end
      tcee_pkg::ST_MV_RD: state_d = tcee_pkg::ST_MV_WR;
      tcee_pkg::ST_MV_WR: begin
        if (mv_len_q == AW'(1)) state_d = tcee_pkg::ST_FILL;
        else state_d = tcee_pkg::ST_MV_RD;
      end
      tcee_pkg::ST_FILL: begin
        if (fill_len_q == '0 || fill_pos_q >= AW'(tcee_pkg::BUF_CELLS)) begin
          state_d = view_q ? tcee_pkg::ST_VIEW : tcee_pkg::ST_DONE;
        end
      end
      tcee_pkg::ST_VIEW: begin
        if (in_view || guard_q == tcee_pkg::GUARD_W'(tcee_pkg::GUARD_MAX)) begin
          state_d = tcee_pkg::ST_DONE;
        end else if (vup == vline_q) begin
          state_d = tcee_pkg::ST_DONE;
        end else begin
          state_d = tcee_pkg::ST_FILL;
        end
      end
      tcee_pkg::ST_RD_WAIT: state_d = tcee_pkg::ST_DONE;
      tcee_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = tcee_pkg::ST_IDLE;
      end
      default: state_d = tcee_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    int x, y, c, v, n, room, base, cnt, t, p, ny, nx, ms, md, ml, fp, fl;
    logic mb, run, csi;

    clr_d      = clr_q;
    func_d     = func_q;
    ch_d       = ch_q;
    addr_d     = addr_q;
    row_d      = row_q;
    col_d      = col_q;
    vline_d    = vline_q;
    full_d     = full_q;
    esc_d      = esc_q;
    intro_d    = intro_q;
    par_d      = par_q;
    pidx_d     = pidx_q;
    mv_src_d   = mv_src_q;
    mv_dst_d   = mv_dst_q;
    mv_len_d   = mv_len_q;
    mv_bwd_d   = mv_bwd_q;
    fill_pos_d = fill_pos_q;
    fill_len_d = fill_len_q;
    view_d     = view_q;
    guard_d    = guard_q;
    data_d     = data_q;
    out_cur_d  = out_cur_q;
    out_vs_d   = out_vs_q;
    out_data_d = out_data_q;
    out_wrap_d = out_wrap_q;
    out_valid_d = out_valid_q & out_stall_i;
    ram_we     = 1'b0;
    ram_addr   = fill_pos_q;
    ram_wdata  = blank;

    x = int'(col_q);
    y = int'(row_q);
    c = int'(cur_pos);
    v = int'(par_q[0]);
    n = (v == 0) ? 1 : v;
    room = 0; base = 0; cnt = 0; t = 0; p = 0; ny = y; nx = x;
    ms = 0; md = 0; ml = 0; fp = 0; fl = 0;
    mb = 1'b0; run = 1'b0; csi = 1'b0;

    case (state_q)
      tcee_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = {tcee_pkg::COLOR_RST, tcee_pkg::CH_SPACE};
        clr_d     = clr_q + AW'(1);
      end
      tcee_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          ch_d   = ch_i;
          addr_d = cell_addr_i;
          data_d = '0;
        end
      end
      tcee_pkg::ST_EXEC: begin
        view_d  = 1'b0;
        guard_d = '0;
        case (func_q)
          tcee_pkg::FN_UP:   vline_d = f_view_up(vline_q, row_q, full_q);
          tcee_pkg::FN_DOWN: vline_d = f_view_down(vline_q, row_q, full_q);
          tcee_pkg::FN_READ: ram_addr = addr_q;
          default: begin
            case (esc_q)
              tcee_pkg::ESC_START: begin
                intro_d = 1'b0;
                for (int i = 0; i < tcee_pkg::ESC_PARAMS; i++) par_d[i] = '0;
                pidx_d = '0;
                esc_d  = tcee_pkg::ESC_NONE;
                if (ch_q == tcee_pkg::CH_LBR) begin
                  intro_d = 1'b1;
                  esc_d   = tcee_pkg::ESC_CSI;
                end else if (ch_q == tcee_pkg::CH_M) begin
                  run = 1'b1;
                  v   = 0;
                end
              end
              tcee_pkg::ESC_CSI: begin
                if (ch_q inside {[tcee_pkg::CH_0:tcee_pkg::CH_9]}) begin
                  for (int i = 0; i < tcee_pkg::ESC_PARAMS; i++) begin
                    if (pidx_q == tcee_pkg::PIDX_W'(i)) begin
                      p = int'(par_q[i]) * 10 + int'(ch_q - tcee_pkg::CH_0);
                      par_d[i] = (p > int'(tcee_pkg::PMAX)) ? tcee_pkg::PMAX
                                                            : tcee_pkg::PARAM_W'(p);
                    end
                  end
                end else if (ch_q == tcee_pkg::CH_SEMI) begin
                  if (pidx_q < tcee_pkg::PIDX_W'(tcee_pkg::ESC_PARAMS)) begin
                    pidx_d = pidx_q + tcee_pkg::PIDX_W'(1);
                  end
                end else begin
                  run = 1'b1;
                  csi = intro_q;
                end
              end
              tcee_pkg::ESC_NONE: begin
                case (ch_q)
                  tcee_pkg::CH_BEL: ;
                  tcee_pkg::CH_LF: begin
                    ny = y + 1;
                    nx = 0;
                  end
                  tcee_pkg::CH_BS: begin
                    if (c > 0) begin
                      if (x == 0) begin
                        ny = y - 1;
                        nx = tcee_pkg::COLS - 1;
                      end else begin
                        nx = x - 1;
                      end
                      ram_we   = 1'b1;
                      ram_addr = AW'(c - 1);
                    end
                  end
                  tcee_pkg::CH_CR: nx = 0;
                  tcee_pkg::CH_TAB: begin
                    t = (x / tcee_pkg::TAB_WIDTH + 1) * tcee_pkg::TAB_WIDTH;
                    if (t >= tcee_pkg::COLS) begin
                      ny = y + 1;
                      nx = t - tcee_pkg::COLS;
                    end else begin
                      nx = t;
                    end
                  end
                  tcee_pkg::CH_ESC: esc_d = tcee_pkg::ESC_START;
                  default: begin
                    ram_we    = 1'b1;
                    ram_addr  = cur_pos;
                    ram_wdata = {color_q, ch_q};
                    if (x + 1 >= tcee_pkg::COLS) begin
                      ny = y + 1;
                      nx = 0;
                    end else begin
                      nx = x + 1;
                    end
                  end
                endcase
                if (ch_q != tcee_pkg::CH_ESC) begin
                  view_d = 1'b1;
                  // Running off the end keeps the last screen minus one line at
                  // the top of the buffer and blanks the line below it.
                  if (ny >= tcee_pkg::BUF_LINES) begin
                    md = 0;
                    ms = (ny + 1) * tcee_pkg::COLS - tcee_pkg::SCR_CELLS;
                    ml = tcee_pkg::SCR_CELLS - tcee_pkg::COLS;
                    fp = tcee_pkg::SCR_CELLS - tcee_pkg::COLS;
                    fl = tcee_pkg::COLS;
                    vline_d = '0;
                    ny = tcee_pkg::ROWS - 1;
                    full_d = 1'b1;
                  end
                  row_d = tcee_pkg::ROW_W'(ny);
                  col_d = tcee_pkg::COL_W'(nx);
                end
              end
              default: esc_d = tcee_pkg::ESC_NONE;
            endcase

            if (run) begin
              esc_d = tcee_pkg::ESC_NONE;
              if (!csi) begin
                if (y == 0) vline_d = f_view_down(vline_q, row_q, full_q);
                else row_d = tcee_pkg::ROW_W'(y - 1);
              end else begin
                case (ch_q)
                  tcee_pkg::CH_A: row_d = tcee_pkg::ROW_W'((n > y) ? 0 : y - n);
                  tcee_pkg::CH_B: begin
                    t = y + n;
                    if (t > tcee_pkg::BUF_LINES - 1) t = tcee_pkg::BUF_LINES - 1;
                    row_d = tcee_pkg::ROW_W'(t);
                  end
                  tcee_pkg::CH_C: begin
                    t = x + n;
                    if (t > tcee_pkg::COLS - 1) t = tcee_pkg::COLS - 1;
                    col_d = tcee_pkg::COL_W'(t);
                  end
                  tcee_pkg::CH_D: col_d = tcee_pkg::COL_W'((n > x) ? 0 : x - n);
                  tcee_pkg::CH_H: begin
                    t = ((v < 1) ? 1 : v) - 1;
                    if (t > tcee_pkg::BUF_LINES - 1) t = tcee_pkg::BUF_LINES - 1;
                    row_d = tcee_pkg::ROW_W'(t);
                    t = ((int'(par_q[1]) < 1) ? 1 : int'(par_q[1])) - 1;
                    if (t > tcee_pkg::COLS - 1) t = tcee_pkg::COLS - 1;
                    col_d = tcee_pkg::COL_W'(t);
                  end
                  tcee_pkg::CH_J: begin
                    if (v == 0) begin
                      fp = c;
                      fl = (c < tcee_pkg::SCR_CELLS) ? tcee_pkg::SCR_CELLS - c : 0;
                    end else if (v == 1) begin
                      fl = c;
                    end else if (v == 2) begin
                      fl = tcee_pkg::SCR_CELLS;
                    end
                  end
                  tcee_pkg::CH_K: begin
                    if (v == 0) begin
                      fp = c;
                      fl = tcee_pkg::COLS - x;
                    end else if (v == 1) begin
                      fp = c - x;
                      fl = x;
                    end else if (v == 2) begin
                      fp = c - x;
                      fl = tcee_pkg::COLS;
                    end
                  end
                  tcee_pkg::CH_L, tcee_pkg::CH_M: begin
                    room = (y < tcee_pkg::ROWS) ? tcee_pkg::ROWS - y : 0;
                    if (n > room) n = room;
                    if (n != 0) begin
                      base = y * tcee_pkg::COLS;
                      cnt  = (tcee_pkg::ROWS - y - n) * tcee_pkg::COLS;
                      ml   = cnt;
                      fl   = n * tcee_pkg::COLS;
                      if (ch_q == tcee_pkg::CH_L) begin
                        md = base + n * tcee_pkg::COLS;
                        ms = base;
                        mb = 1'b1;
                        fp = base;
                      end else begin
                        md = base;
                        ms = base + n * tcee_pkg::COLS;
                        fp = base + cnt;
                      end
                    end
                  end
                  tcee_pkg::CH_AT, tcee_pkg::CH_P: begin
                    if (n > tcee_pkg::COLS - x) n = tcee_pkg::COLS - x;
                    cnt = tcee_pkg::COLS - x - n;
                    ml  = cnt;
                    fl  = n;
                    if (ch_q == tcee_pkg::CH_AT) begin
                      md = c + n;
                      ms = c;
                      mb = 1'b1;
                      fp = c;
                    end else begin
                      md = c;
                      ms = c + n;
                      fp = c + cnt;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end
        endcase

        // Moves are clipped at the end of the buffer; an overlapping move to
        // a higher address runs from the top down.
        if (md >= tcee_pkg::BUF_CELLS || ms >= tcee_pkg::BUF_CELLS) ml = 0;
        if (ml > tcee_pkg::BUF_CELLS - ms) ml = tcee_pkg::BUF_CELLS - ms;
        if (ml > tcee_pkg::BUF_CELLS - md) ml = tcee_pkg::BUF_CELLS - md;
        mv_len_d   = AW'(ml);
        mv_bwd_d   = mb;
        mv_src_d   = mb ? AW'(ms + ml - 1) : AW'(ms);
        mv_dst_d   = mb ? AW'(md + ml - 1) : AW'(md);
        fill_pos_d = AW'(fp);
        fill_len_d = AW'(fl);
      end
      tcee_pkg::ST_MV_RD: ram_addr = mv_src_q;
      tcee_pkg::ST_MV_WR: begin
        ram_we    = 1'b1;
        ram_addr  = mv_dst_q;
        ram_wdata = ram_rdata;
        mv_len_d  = mv_len_q - AW'(1);
        if (mv_bwd_q) begin
          mv_src_d = mv_src_q - AW'(1);
          mv_dst_d = mv_dst_q - AW'(1);
        end else begin
          mv_src_d = mv_src_q + AW'(1);
          mv_dst_d = mv_dst_q + AW'(1);
        end
      end
      tcee_pkg::ST_FILL: begin
        if (fill_len_q != '0 && fill_pos_q < AW'(tcee_pkg::BUF_CELLS)) begin
          ram_we     = 1'b1;
          fill_pos_d = fill_pos_q + AW'(1);
          fill_len_d = fill_len_q - AW'(1);
        end
      end
      tcee_pkg::ST_VIEW: begin
        // Each step scrolls the view one line and blanks a line's worth of cells
        // from the cursor; a view that cannot scroll jumps to the cursor line, or to the last full screen.
        if (!(in_view || guard_q == tcee_pkg::GUARD_W'(tcee_pkg::GUARD_MAX))) begin
          if (vup == vline_q) begin
            t = (y > tcee_pkg::BUF_LINES - tcee_pkg::ROWS) ?
                tcee_pkg::BUF_LINES - tcee_pkg::ROWS : y;
            vline_d = tcee_pkg::VL_W'(t);
          end else begin
            vline_d    = vup;
            fill_pos_d = cur_pos;
            fill_len_d = AW'(tcee_pkg::COLS);
            guard_d    = guard_q + tcee_pkg::GUARD_W'(1);
          end
        end
      end
      tcee_pkg::ST_RD_WAIT: data_d = ram_rdata;
      tcee_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_cur_d   = cur_pos;
          out_vs_d    = AW'(int'(vline_q) * tcee_pkg::COLS);
          out_data_d  = data_q;
          out_wrap_d  = full_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcee_pkg::ST_CLEAR;
      clr_q       <= '0;
      color_q     <= tcee_pkg::COLOR_RST;
      row_q       <= '0;
      col_q       <= '0;
      vline_q     <= '0;
      full_q      <= 1'b0;
      esc_q       <= tcee_pkg::ESC_NONE;
      intro_q     <= 1'b0;
      for (int i = 0; i < tcee_pkg::ESC_PARAMS; i++) par_q[i] <= '0;
      pidx_q      <= '0;
      view_q      <= 1'b0;
      guard_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      if (cfg_we_i) color_q <= cfg_data_i;
      row_q       <= row_d;
      col_q       <= col_d;
      vline_q     <= vline_d;
      full_q      <= full_d;
      esc_q       <= esc_d;
      intro_q     <= intro_d;
      par_q       <= par_d;
      pidx_q      <= pidx_d;
      view_q      <= view_d;
      guard_q     <= guard_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    ch_q       <= ch_d;
    addr_q     <= addr_d;
    mv_src_q   <= mv_src_d;
    mv_dst_q   <= mv_dst_d;
    mv_len_q   <= mv_len_d;
    mv_bwd_q   <= mv_bwd_d;
    fill_pos_q <= fill_pos_d;
    fill_len_q <= fill_len_d;
    data_q     <= data_d;
    out_cur_q  <= out_cur_d;
    out_vs_q   <= out_vs_d;
    out_data_q <= out_data_d;
    out_wrap_q <= out_wrap_d;
  end

  assign in_stall_o       = (state_q != tcee_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign cursor_pos_o     = out_cur_q;
  assign display_start_o  = out_vs_q;
  assign cell_data_o      = out_data_q;
  assign buffer_wrapped_o = out_wrap_q;

`ifndef SYNTHESIS
  a_cursor_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcee_pkg::ST_IDLE |->
      (col_q < tcee_pkg::COL_W'(tcee_pkg::COLS)) &&
      (row_q < tcee_pkg::ROW_W'(tcee_pkg::BUF_LINES)))
    else $error("cursor outside the buffer between requests");

  a_view_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vline_q <= tcee_pkg::VL_W'(tcee_pkg::BUF_LINES - tcee_pkg::ROWS))
    else $error("display start past the last full screen");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(full_q))
    else $error("wrap flag cleared");
`endif

endmodule
`default_nettype wire
